/* rtl/core/bit_buffer_field_packer_unit_macros.svh */
// Assertion macros used by the bit buffer field packer assertion checker.
`ifndef BIT_BUFFER_FIELD_PACKER_UNIT_MACROS_SVH
`define BIT_BUFFER_FIELD_PACKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define BBFP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bbfp assertion failed");

// Next-cycle implication, disabled while rst is high.
`define BBFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bbfp assertion failed");

`endif

/* rtl/core/bbfp_pkg.sv */
// Shared types, codes and constants of the bit buffer field packer.
package bbfp_pkg;

   localparam int DATA_BYTES_DEF = 64;
   localparam int AUX_BITS_DEF   = 128;
   localparam int BYTE_BITS      = 8;
   localparam int PTR_MAX        = 255;

   localparam int MODE_W    = 3;
   localparam int POS_W     = 10;
   localparam int POS_XW    = POS_W + 1;
   localparam int VALUE_W   = 32;
   localparam int FWIDTH_W  = 6;
   localparam int CNT_W     = 5;
   localparam int DELTA_W   = 8;
   localparam int PTR_W     = 8;
   localparam int STATUS_W  = 2;

   localparam logic [FWIDTH_W-1:0] FIELD_W_MAX = 6'd32;

   localparam logic [MODE_W-1:0] MODE_GET_BIT     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SET_BIT     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_WRITE_FIELD = 3'd2;
   localparam logic [MODE_W-1:0] MODE_READ_FIELD  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ADD_BASE    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_SUB_BASE    = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FIT   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_UNDER = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [POS_W-1:0]    position;
      logic                bit_value;
      logic [VALUE_W-1:0]  field_value;
      logic [FWIDTH_W-1:0] field_width;
      logic [DELTA_W-1:0]  base_delta;
   } req_type;

   typedef struct packed {
      logic                read_bit;
      logic [VALUE_W-1:0]  read_value;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

/* rtl/core/bit_buffer_field_packer_unit.sv */
// Top level of the bit buffer field packer: bit store, base pointer, cursor, serial fields.
//
//   channel  | valid      | ready      | payload
//   ---------+------------+------------+-------------------------
//   request  | req_valid  | req_ready  | req_data (req_type)
//   response | rsp_valid  | rsp_ready  | rsp_data (rsp_type)
//
// Set bit, base moves and rejected requests go from idle straight to finish; get bit
// passes a RAM read state first. Write and read field walk the field bit by bit, read
// field adding a tail state for the lagging RAM data; fields move one bit per cycle
// through the aux bit RAM, its write port for writes and its read port for reads.
// After reset a clearing pass zeroes both stores; req_ready stays low until it ends.
// A response waits in the output register; a finished request stalls in the finish
// state until the previous response is taken.
module bit_buffer_field_packer_unit #(
   parameter int DATA_BYTES = bbfp_pkg::DATA_BYTES_DEF,
   parameter int AUX_BITS   = bbfp_pkg::AUX_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bbfp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bbfp_pkg::rsp_type rsp_data
);

   import bbfp_pkg::*;

   localparam int DATA_BITS = DATA_BYTES * BYTE_BITS;
   localparam int DATA_AW   = $clog2(DATA_BITS);
   localparam int AUX_AW    = $clog2(AUX_BITS);
   localparam int CLR_DEPTH = (DATA_BITS > AUX_BITS) ? DATA_BITS : AUX_BITS;
   localparam int CLR_W     = $clog2(CLR_DEPTH);
   localparam int PTR_LIMIT = (AUX_BITS < PTR_MAX) ? AUX_BITS : PTR_MAX;
   localparam int SUM_W     = PTR_W + 1;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_GET, S_WRITE, S_READ, S_RTAIL, S_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [CLR_W-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [PTR_W-1:0]     base_ff, base_in;
   logic [PTR_W-1:0]     cursor_ff, cursor_in;
   logic [PTR_W-1:0]     end_ff, end_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     wm1_ff, wm1_in;
   logic [VALUE_W-1:0]   shift_ff, shift_in;
   logic                 bit_ff, bit_in;
   logic [STATUS_W-1:0]  st_ff, st_in;
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic                 in_data_ff, in_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [POS_XW-1:0]    pos_x;
   logic [POS_XW-1:0]    aux_off;
   logic                 in_data;
   logic                 in_aux;
   logic [FWIDTH_W-1:0]  fw;
   logic                 w_bad;
   logic                 fit_bad;
   logic [SUM_W-1:0]     field_end;
   logic                 end_bad;
   logic [SUM_W-1:0]     base_sum;
   logic [SUM_W-1:0]     fsum;
   logic                 clr_lt_data;
   logic                 clr_lt_aux;

   logic                 d_we;
   logic [DATA_AW-1:0]   d_waddr;
   logic                 d_wbit;
   logic                 d_rbit;
   logic                 a_we;
   logic [AUX_AW-1:0]    a_waddr;
   logic                 a_wbit;
   logic [AUX_AW-1:0]    a_raddr;
   logic                 a_rbit;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign pos_x     = {1'b0, req_data.position};
   assign in_data   = pos_x < POS_XW'(DATA_BITS);
   assign aux_off   = pos_x - POS_XW'(DATA_BITS);
   assign in_aux    = !in_data && (aux_off < POS_XW'(AUX_BITS));
   assign fw        = req_data.field_width;
   assign w_bad     = (fw == '0) || (fw > FIELD_W_MAX);
   assign fit_bad   = (fw < FIELD_W_MAX) && ((req_data.field_value >> fw[CNT_W-1:0]) != '0);
   assign field_end = {1'b0, cursor_ff} + SUM_W'(fw);
   assign end_bad   = field_end > SUM_W'(PTR_LIMIT);
   assign base_sum  = {1'b0, base_ff} + {1'b0, req_data.base_delta};
   assign fsum      = {1'b0, cursor_ff} + SUM_W'(cnt_ff);

   assign clr_lt_data = {1'b0, clr_cnt_ff} < (CLR_W + 1)'(DATA_BITS);
   assign clr_lt_aux  = {1'b0, clr_cnt_ff} < (CLR_W + 1)'(AUX_BITS);

   // Field reads walk the cursor; a get bit reads at the request position.
   assign a_raddr = (state_ff == S_READ) ? fsum[AUX_AW-1:0] : aux_off[AUX_AW-1:0];

   bbfp_bit_ram #(.DEPTH(DATA_BITS)) u_data_ram (
      .clock   (clock),
      .wr_en   (d_we),
      .wr_addr (d_waddr),
      .wr_bit  (d_wbit),
      .rd_addr (pos_x[DATA_AW-1:0]),
      .rd_bit  (d_rbit)
   );

   bbfp_bit_ram #(.DEPTH(AUX_BITS)) u_aux_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_bit  (a_wbit),
      .rd_addr (a_raddr),
      .rd_bit  (a_rbit)
   );

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      base_in      = base_ff;
      cursor_in    = cursor_ff;
      end_in       = end_ff;
      cnt_in       = cnt_ff;
      wm1_in       = wm1_ff;
      shift_in     = shift_ff;
      bit_in       = bit_ff;
      st_in        = st_ff;
      mode_in      = mode_ff;
      in_data_in   = in_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      d_we         = 1'b0;
      d_waddr      = clr_cnt_ff[DATA_AW-1:0];
      d_wbit       = 1'b0;
      a_we         = 1'b0;
      a_waddr      = clr_cnt_ff[AUX_AW-1:0];
      a_wbit       = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            d_we = clr_lt_data;
            a_we = clr_lt_aux;
            if (clr_cnt_ff == CLR_W'(CLR_DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               mode_in    = req_data.mode;
               in_data_in = in_data;
               shift_in   = req_data.field_value;
               bit_in     = 1'b0;
               st_in      = ST_OK;
               cnt_in     = fw[CNT_W-1:0] - 1'b1;
               wm1_in     = fw[CNT_W-1:0] - 1'b1;
               end_in     = field_end[PTR_W-1:0];
               state_in   = S_FINISH;
               unique case (req_data.mode)
                  MODE_GET_BIT: begin
                     if (!in_data && !in_aux) begin
                        st_in = ST_RANGE;
                     end else begin
                        state_in = S_GET;
                     end
                  end
                  MODE_SET_BIT: begin
                     if (in_data) begin
                        d_we    = 1'b1;
                        d_waddr = pos_x[DATA_AW-1:0];
                        d_wbit  = req_data.bit_value;
                     end else if (in_aux) begin
                        a_we    = 1'b1;
                        a_waddr = aux_off[AUX_AW-1:0];
                        a_wbit  = req_data.bit_value;
                     end else begin
                        st_in = ST_RANGE;
                     end
                  end
                  MODE_WRITE_FIELD: begin
                     if (w_bad) begin
                        st_in = ST_RANGE;
                     end else if (fit_bad) begin
                        st_in = ST_FIT;
                     end else if (end_bad) begin
                        st_in = ST_RANGE;
                     end else begin
                        state_in = S_WRITE;
                     end
                  end
                  MODE_READ_FIELD: begin
                     shift_in = '0;
                     if (w_bad || end_bad) begin
                        st_in = ST_RANGE;
                     end else begin
                        cnt_in   = '0;
                        state_in = S_READ;
                     end
                  end
                  MODE_ADD_BASE: begin
                     if (base_sum > SUM_W'(PTR_LIMIT)) begin
                        st_in = ST_RANGE;
                     end else begin
                        base_in   = base_sum[PTR_W-1:0];
                        cursor_in = base_sum[PTR_W-1:0];
                     end
                  end
                  MODE_SUB_BASE: begin
                     if (req_data.base_delta > base_ff) begin
                        st_in = ST_UNDER;
                     end else begin
                        base_in   = base_ff - req_data.base_delta;
                        cursor_in = base_ff - req_data.base_delta;
                     end
                  end
                  default: begin
                     st_in = ST_RANGE;
                  end
               endcase
            end
         end
         S_GET: begin
            bit_in   = in_data_ff ? d_rbit : a_rbit;
            state_in = S_FINISH;
         end
         S_WRITE: begin
            // LSB goes to the far end of the field, so shift right and count down.
            a_we     = 1'b1;
            a_waddr  = fsum[AUX_AW-1:0];
            a_wbit   = shift_ff[0];
            shift_in = shift_ff >> 1;
            if (cnt_ff == '0) begin
               cursor_in = end_ff;
               state_in  = S_FINISH;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_READ: begin
            // RAM read data is registered, so each bit arrives in the cycle after its address.
            if (cnt_ff != '0) begin
               shift_in = {shift_ff[VALUE_W-2:0], a_rbit};
            end
            if (cnt_ff == wm1_ff) begin
               state_in = S_RTAIL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_RTAIL: begin
            shift_in  = {shift_ff[VALUE_W-2:0], a_rbit};
            cursor_in = end_ff;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.read_bit    = bit_ff;
               rsp_in.read_value  = (mode_ff == MODE_READ_FIELD && st_ff == ST_OK) ?
                                    shift_ff : '0;
               rsp_in.status      = st_ff;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         base_ff      <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         base_ff      <= base_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      end_ff     <= end_in;
      cnt_ff     <= cnt_in;
      wm1_ff     <= wm1_in;
      shift_ff   <= shift_in;
      bit_ff     <= bit_in;
      st_ff      <= st_in;
      mode_ff    <= mode_in;
      in_data_ff <= in_data_in;
      rsp_ff     <= rsp_in;
   end

endmodule

/* rtl/core/bbfp_bit_ram.sv */
// One-bit-wide RAM with one write port and one registered read port.
module bbfp_bit_ram #(
   parameter int DEPTH = bbfp_pkg::AUX_BITS_DEF,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_bit,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_bit
);

   logic mem [DEPTH];
   logic rd_bit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_bit;
      end
      rd_bit_ff <= mem[rd_addr];
   end

   assign rd_bit = rd_bit_ff;

endmodule

/* rtl/core/bbfp_checker.sv */
// Port-level assertion checker for the bit buffer field packer, bound to the top level.
`include "bit_buffer_field_packer_unit_macros.svh"

module bbfp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input bbfp_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bbfp_pkg::rsp_type rsp_data
);

   import bbfp_pkg::*;

   // Stalled response holds until the transfer.
   `BBFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // A returned bit only comes with a good status.
   `BBFP_ASSERT_SAME(a_bit_ok, clock, reset, rsp_valid && rsp_data.read_bit, rsp_data.status == ST_OK)

   // A returned field only comes with a good status.
   `BBFP_ASSERT_SAME(a_value_ok, clock, reset, rsp_valid && (rsp_data.read_value != '0), rsp_data.status == ST_OK)

   // A response never carries both a bit and a field.
   `BBFP_ASSERT_SAME(a_one_kind, clock, reset, rsp_valid, !rsp_data.read_bit || (rsp_data.read_value == '0))

   // Right after reset nothing is shown and the clearing pass blocks requests.
   `BBFP_ASSERT_SAME(a_reset_quiet, clock, reset, $past(reset), !rsp_valid && !req_ready)

endmodule

bind bit_buffer_field_packer_unit bbfp_checker u_bbfp_checker (.*);

/* tb/bit_buffer_field_packer_unit_checker.sv */
// Response checker for the bit buffer field packer: predicts every response and compares it.
`timescale 1ns / 100ps
module bit_buffer_field_packer_unit_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  bbfp_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  bbfp_pkg::rsp_type rsp_data,
   output int unsigned       mismatch_count,
   output int unsigned       outstanding,
   output int unsigned       checked_count
);
   import bbfp_pkg::*;

   localparam int DATA_BITS   = DATA_BYTES_DEF * BYTE_BITS;
   localparam int AUX_BITS    = AUX_BITS_DEF;
   // a field must end inside the aux bits and within reach of the 8-bit cursor
   localparam int PTR_LIMIT   = (AUX_BITS_DEF < PTR_MAX) ? AUX_BITS_DEF : PTR_MAX;
   localparam int PRINT_LIMIT = 40;

   logic        data_mirror [DATA_BITS];
   logic        aux_mirror  [AUX_BITS];
   int unsigned base_ptr;
   int unsigned cursor;
   rsp_type     predicted_rsp_q [$];
   rsp_type     want_rsp;
   rsp_type     next_rsp;

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t: response mismatch on %s: got 0x%0h, expected 0x%0h",
                  $time, what, got, want);
   endtask

   // Apply one request to the mirrored store and return its response.
   function automatic rsp_type apply_access(input req_type cmd);
      rsp_type     res;
      int unsigned pos;
      int unsigned w;
      int unsigned delta;
      int unsigned i;
      res        = '0;
      res.status = ST_OK;
      pos        = 32'(cmd.position);
      w          = 32'(cmd.field_width);
      delta      = 32'(cmd.base_delta);
      case (cmd.mode)
         MODE_GET_BIT: begin
            if (pos < DATA_BITS)
               res.read_bit = data_mirror[pos];
            else if (pos < DATA_BITS + AUX_BITS)
               res.read_bit = aux_mirror[pos - DATA_BITS];
            else
               res.status = ST_RANGE;
         end
         MODE_SET_BIT: begin
            if (pos < DATA_BITS)
               data_mirror[pos] = cmd.bit_value;
            else if (pos < DATA_BITS + AUX_BITS)
               aux_mirror[pos - DATA_BITS] = cmd.bit_value;
            else
               res.status = ST_RANGE;
         end
         MODE_WRITE_FIELD: begin
            if (w == 0 || w > VALUE_W)
               res.status = ST_RANGE;
            else if (w < VALUE_W && (cmd.field_value >> w) != 0)
               res.status = ST_FIT;
            else if (cursor + w > PTR_LIMIT)
               res.status = ST_RANGE;
            else begin
               for (i = 0; i < w; i++)
                  aux_mirror[cursor + i] = cmd.field_value[w - 1 - i];
               cursor += w;
            end
         end
         MODE_READ_FIELD: begin
            if (w == 0 || w > VALUE_W || cursor + w > PTR_LIMIT)
               res.status = ST_RANGE;
            else begin
               for (i = 0; i < w; i++)
                  res.read_value = {res.read_value[VALUE_W-2:0], aux_mirror[cursor + i]};
               cursor += w;
            end
         end
         MODE_ADD_BASE: begin
            if (base_ptr + delta > PTR_LIMIT)
               res.status = ST_RANGE;
            else begin
               base_ptr += delta;
               cursor    = base_ptr;
            end
         end
         MODE_SUB_BASE: begin
            if (delta > base_ptr)
               res.status = ST_UNDER;
            else begin
               base_ptr -= delta;
               cursor    = base_ptr;
            end
         end
         default: begin
            res.status = ST_RANGE;
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (data_mirror[k]) data_mirror[k] = 1'b0;
         foreach (aux_mirror[k]) aux_mirror[k] = 1'b0;
         base_ptr       = 0;
         cursor         = 0;
         predicted_rsp_q.delete();
         mismatch_count = 0;
         checked_count  = 0;
         outstanding   <= 0;
      end else begin
         // compare before queueing: a request never answers in its own cycle
         if (rsp_valid && rsp_ready) begin
            checked_count++;
            if (predicted_rsp_q.size() == 0)
               report_mismatch("unexpected response", 64'(rsp_data), 64'(0));
            else begin
               want_rsp = predicted_rsp_q.pop_front();
               if (rsp_data.read_bit !== want_rsp.read_bit)
                  report_mismatch("read_bit", 64'(rsp_data.read_bit),
                                  64'(want_rsp.read_bit));
               if (rsp_data.read_value !== want_rsp.read_value)
                  report_mismatch("read_value", 64'(rsp_data.read_value),
                                  64'(want_rsp.read_value));
               if (rsp_data.status !== want_rsp.status)
                  report_mismatch("status", 64'(rsp_data.status), 64'(want_rsp.status));
            end
         end
         if (req_valid && req_ready) begin
            next_rsp        = apply_access(req_data);
            predicted_rsp_q = {predicted_rsp_q, next_rsp};
         end
         outstanding <= predicted_rsp_q.size();
      end
   end

endmodule

/* tb/bit_buffer_field_packer_unit_tb.sv */
// Testbench top for the bit buffer field packer: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module bit_buffer_field_packer_unit_tb;
   import bbfp_pkg::*;

   localparam int ITEM_TARGET    = 1650;
   localparam int TAIL_START     = ITEM_TARGET * 85 / 100;
   localparam int MID_DRAIN_AT   = ITEM_TARGET / 2;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int DATA_BITS      = DATA_BYTES_DEF * BYTE_BITS;
   localparam int STORE_BITS     = DATA_BITS + AUX_BITS_DEF;
   localparam int MAX_FIELDS     = 5;

   localparam logic [MODE_W-1:0] MODE_RSVD_6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_RSVD_7 = 3'd7;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   int unsigned mismatch_count;
   int unsigned outstanding;
   int unsigned checked_count;
   int unsigned sent_count   = 0;
   int unsigned round_trips  = 0;
   int unsigned idle_pct     = 0;
   int unsigned quiet_cycles = 0;

   bit_buffer_field_packer_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   bit_buffer_field_packer_unit_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .checked_count  (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response side: stall in bursts whose density follows the sender's phase.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct / 2) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("bit_buffer_field_packer_unit_tb: FAIL");
         $finish;
      end
   end

   function automatic req_type random_req();
      req_type r;
      r.mode        = MODE_W'($urandom_range(0, 7));
      r.position    = POS_W'($urandom_range(0, 1023));
      r.bit_value   = 1'($urandom_range(0, 1));
      r.field_value = $urandom;
      r.field_width = FWIDTH_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                            : $urandom_range(1, 32));
      r.base_delta  = DELTA_W'($urandom_range(0, 255));
      return r;
   endfunction

   task automatic send_req(input req_type item);
      if (sent_count >= TAIL_START)
         idle_pct = 0;
      else begin
         case ((sent_count / 150) % 4)
            0: idle_pct = 20;
            1: idle_pct = 0;
            2: idle_pct = 45;
            default: idle_pct = 8;
         endcase
      end
      if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   task automatic send_op(input logic [MODE_W-1:0] mode, input int unsigned position,
                          input logic bit_value, input logic [VALUE_W-1:0] field_value,
                          input int unsigned field_width, input int unsigned base_delta);
      req_type r;
      r.mode        = mode;
      r.position    = POS_W'(position);
      r.bit_value   = bit_value;
      r.field_value = field_value;
      r.field_width = FWIDTH_W'(field_width);
      r.base_delta  = DELTA_W'(base_delta);
      send_req(r);
   endtask

   // Hold off the sender until every predicted response has been taken.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      req_type     cmd;
      int unsigned widths [MAX_FIELDS];
      int unsigned nfields;
      int unsigned pick;
      int unsigned directed_count;
      bit          mid_drained;
      mid_drained = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // single bits at the edges of the data and aux regions, and past the store
      send_op(MODE_GET_BIT, 0, 1'b0, '0, 1, 0);
      send_op(MODE_GET_BIT, DATA_BITS, 1'b0, '0, 1, 0);
      send_op(MODE_GET_BIT, STORE_BITS - 1, 1'b0, '0, 1, 0);
      send_op(MODE_GET_BIT, STORE_BITS, 1'b0, '0, 1, 0);
      send_op(MODE_SET_BIT, 0, 1'b1, '0, 1, 0);
      send_op(MODE_SET_BIT, DATA_BITS - 1, 1'b1, '0, 1, 0);
      send_op(MODE_SET_BIT, STORE_BITS - 1, 1'b1, '0, 1, 0);
      send_op(MODE_SET_BIT, 1023, 1'b1, '0, 1, 0);
      send_op(MODE_GET_BIT, 0, 1'b0, '0, 1, 0);
      send_op(MODE_GET_BIT, DATA_BITS - 1, 1'b0, '0, 1, 0);
      send_op(MODE_GET_BIT, STORE_BITS - 1, 1'b0, '0, 1, 0);
      // fields: widest, narrowest, bad widths, value too wide
      send_op(MODE_WRITE_FIELD, 0, 1'b0, 32'hFFFF_FFFF, 32, 0);
      send_op(MODE_WRITE_FIELD, 0, 1'b0, 32'd1, 1, 0);
      send_op(MODE_WRITE_FIELD, 0, 1'b0, 32'd0, 0, 0);
      send_op(MODE_WRITE_FIELD, 0, 1'b0, 32'd5, 63, 0);
      send_op(MODE_WRITE_FIELD, 0, 1'b0, 32'd16, 4, 0);
      send_op(MODE_SUB_BASE, 0, 1'b0, '0, 1, 0);
      send_op(MODE_READ_FIELD, 0, 1'b0, '0, 32, 0);
      send_op(MODE_READ_FIELD, 0, 1'b0, '0, 1, 0);
      send_op(MODE_READ_FIELD, 0, 1'b0, '0, 33, 0);
      // base at the top, cursor limit, overflow and underflow
      send_op(MODE_ADD_BASE, 0, 1'b0, '0, 1, AUX_BITS_DEF);
      send_op(MODE_WRITE_FIELD, 0, 1'b0, 32'd1, 1, 0);
      send_op(MODE_ADD_BASE, 0, 1'b0, '0, 1, 1);
      send_op(MODE_SUB_BASE, 0, 1'b0, '0, 1, 255);
      send_op(MODE_SUB_BASE, 0, 1'b0, '0, 1, AUX_BITS_DEF);
      send_op(MODE_RSVD_6, 0, 1'b0, '0, 1, 0);
      send_op(MODE_RSVD_7, 0, 1'b0, '0, 1, 0);
      directed_count = sent_count;

      while (sent_count < ITEM_TARGET) begin
         if (!mid_drained && sent_count >= MID_DRAIN_AT) begin
            wait_for_drain();
            mid_drained = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            // rewind, write a run of fields, rewind, read them back
            nfields = $urandom_range(1, MAX_FIELDS);
            cmd = random_req();
            cmd.mode       = MODE_SUB_BASE;
            cmd.base_delta = '0;
            send_req(cmd);
            for (int k = 0; k < nfields; k++) begin
               widths[k] = ($urandom_range(0, 3) == 0) ? VALUE_W : $urandom_range(1, 32);
               cmd = random_req();
               cmd.mode        = MODE_WRITE_FIELD;
               cmd.field_width = FWIDTH_W'(widths[k]);
               if (widths[k] < VALUE_W)
                  cmd.field_value = cmd.field_value & ((32'd1 << widths[k]) - 32'd1);
               send_req(cmd);
            end
            cmd = random_req();
            cmd.mode       = MODE_SUB_BASE;
            cmd.base_delta = '0;
            send_req(cmd);
            for (int k = 0; k < nfields; k++) begin
               cmd = random_req();
               cmd.mode        = MODE_READ_FIELD;
               cmd.field_width = FWIDTH_W'(widths[k]);
               send_req(cmd);
            end
            round_trips++;
         end else if (pick < 70) begin
            cmd = random_req();
            if ($urandom_range(0, 1)) begin
               cmd.mode       = MODE_ADD_BASE;
               cmd.base_delta = DELTA_W'($urandom_range(0, 48));
            end else begin
               cmd.mode       = MODE_SUB_BASE;
               cmd.base_delta = DELTA_W'($urandom_range(0, 64));
            end
            send_req(cmd);
         end else begin
            cmd = random_req();
            if ($urandom_range(0, 9) < 6)
               cmd.position = POS_W'($urandom_range(0, STORE_BITS - 1));
            if ($urandom_range(0, 1) && cmd.field_width < VALUE_W)
               cmd.field_value = cmd.field_value & ((32'd1 << cmd.field_width) - 32'd1);
            send_req(cmd);
         end
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d requests: %0d directed, %0d field write/read-back runs,",
               sent_count, directed_count, round_trips);
      $display("plus base moves and random noise; %0d responses compared, %0d mismatches.",
               checked_count, mismatch_count);
      if (mismatch_count == 0 && outstanding == 0)
         $display("bit_buffer_field_packer_unit_tb: PASS");
      else
         $display("bit_buffer_field_packer_unit_tb: FAIL");
      $finish;
   end

endmodule

/* bit_buffer_field_packer_unit.f */
+incdir+rtl/core
rtl/core/bbfp_pkg.sv
rtl/core/bbfp_bit_ram.sv
rtl/core/bit_buffer_field_packer_unit.sv
rtl/core/bbfp_checker.sv
tb/bit_buffer_field_packer_unit_checker.sv
tb/bit_buffer_field_packer_unit_tb.sv
